@@ rtl/dec_pkg.sv @@
// Package with the payload types, widths and shared constants of the disk collision block.
`timescale 1ns / 1ps
package dec_pkg;

  localparam int unsigned CoordWidth = 24;
  localparam int unsigned VelWidth   = 16;
  localparam int unsigned MassWidth  = 8;
  localparam int unsigned SizeWidth  = 8;

  localparam int unsigned CompWidth  = 16;
  localparam int unsigned FactWidth  = MassWidth + 1;
  localparam int unsigned AdotWidth  = VelWidth + 18;
  localparam int unsigned DenWidth   = 42;
  localparam int unsigned QuoWidth   = VelWidth + 1;
  localparam int unsigned FrontLat   = 5;
  localparam int unsigned LaneLat    = QuoWidth + 5;

  typedef struct packed {
    logic signed [CoordWidth-1:0] a_pos_x;
    logic signed [CoordWidth-1:0] a_pos_y;
    logic signed [VelWidth-1:0]   a_vel_x;
    logic signed [VelWidth-1:0]   a_vel_y;
    logic [SizeWidth-1:0]         a_size;
    logic [MassWidth-1:0]         a_mass;
    logic signed [CoordWidth-1:0] b_pos_x;
    logic signed [CoordWidth-1:0] b_pos_y;
    logic signed [VelWidth-1:0]   b_vel_x;
    logic signed [VelWidth-1:0]   b_vel_y;
    logic [SizeWidth-1:0]         b_size;
    logic [MassWidth-1:0]         b_mass;
  } dec_in_t;

  typedef struct packed {
    logic                       hit;
    logic signed [VelWidth-1:0] a_new_vel_x;
    logic signed [VelWidth-1:0] a_new_vel_y;
    logic signed [VelWidth-1:0] b_new_vel_x;
    logic signed [VelWidth-1:0] b_new_vel_y;
  } dec_out_t;

  typedef struct packed {
    logic                       hit;
    logic                       upd;
    logic                       dot_neg;
    logic [AdotWidth-1:0]       adot;
    logic [DenWidth-1:0]        den;
    logic [CompWidth-1:0]       adx;
    logic                       dx_neg;
    logic [CompWidth-1:0]       ady;
    logic                       dy_neg;
    logic [FactWidth-1:0]       fa;
    logic [FactWidth-1:0]       fb;
    logic signed [VelWidth-1:0] avx;
    logic signed [VelWidth-1:0] avy;
    logic signed [VelWidth-1:0] bvx;
    logic signed [VelWidth-1:0] bvy;
  } dec_geo_t;

endpackage

@@ rtl/dec_front.sv @@
// Geometry front end: centres, contact test, dot product and shared denominator.
`timescale 1ns / 1ps
module dec_front (
  input  logic              clk_i,
  input  logic              en_i,
  input  dec_pkg::dec_in_t  in_i,
  output dec_pkg::dec_geo_t geo_o
);
  import dec_pkg::*;

  localparam int unsigned XW  = CoordWidth + 2;
  localparam int unsigned DvW = VelWidth + 1;
  localparam int unsigned PW  = DvW + 17;
  localparam int unsigned DotW = AdotWidth + 1;

  dec_in_t in_q;

  logic signed [XW-1:0]  dx_d, dy_d, dx_q, dy_q;
  logic [15:0]           rsum_d, rsum_q;
  logic signed [DvW-1:0] dvx_d, dvy_d, dvx_q, dvy_q;
  dec_in_t               b_q;

  logic [XW-1:0]         adx_c, ady_c;
  logic                  near_d, near_q;
  logic [31:0]           sqx_d, sqy_d, rsq_d, sqx_q, sqy_q, rsq_q;
  logic signed [PW-1:0]  px_d, py_d, px_q, py_q;
  logic [CompWidth-1:0]  adx_q, ady_q;
  logic                  dxn_q, dyn_q;
  dec_in_t               c_q;

  logic [32:0]           dist2_d, dist2_q;
  logic                  hit_d, hit_q, upd_q;
  logic signed [DotW-1:0] dot_d, dot_q;
  logic [FactWidth-1:0]  m_d, m_q;
  logic [CompWidth-1:0]  adx2_q, ady2_q;
  logic                  dxn2_q, dyn2_q;
  dec_in_t               d_q;

  dec_geo_t              geo_d, geo_q;

  always_comb begin
    dx_d = XW'(in_q.a_pos_x) + XW'({1'b0, in_q.a_size, 7'b0})
         - XW'(in_q.b_pos_x) - XW'({1'b0, in_q.b_size, 7'b0});
    dy_d = XW'(in_q.a_pos_y) + XW'({1'b0, in_q.a_size, 7'b0})
         - XW'(in_q.b_pos_y) - XW'({1'b0, in_q.b_size, 7'b0});
    rsum_d = {(9'(in_q.a_size) + 9'(in_q.b_size)), 7'b0};
    dvx_d = DvW'(in_q.a_vel_x) - DvW'(in_q.b_vel_x);
    dvy_d = DvW'(in_q.a_vel_y) - DvW'(in_q.b_vel_y);
  end

  always_comb begin
    adx_c  = dx_q[XW-1] ? XW'(-dx_q) : XW'(dx_q);
    ady_c  = dy_q[XW-1] ? XW'(-dy_q) : XW'(dy_q);
    near_d = ((dx_q != '0) || (dy_q != '0)) && (adx_c <= XW'(rsum_q))
             && (ady_c <= XW'(rsum_q));
    sqx_d  = 32'(adx_c[15:0]) * 32'(adx_c[15:0]);
    sqy_d  = 32'(ady_c[15:0]) * 32'(ady_c[15:0]);
    rsq_d  = 32'(rsum_q) * 32'(rsum_q);
    px_d   = PW'(dvx_q) * PW'($signed(dx_q[16:0]));
    py_d   = PW'(dvy_q) * PW'($signed(dy_q[16:0]));
  end

  always_comb begin
    dist2_d = 33'(sqx_q) + 33'(sqy_q);
    hit_d   = near_q && (dist2_d <= 33'(rsq_q));
    dot_d   = DotW'(px_q) + DotW'(py_q);
    m_d     = FactWidth'(c_q.a_mass) + FactWidth'(c_q.b_mass);
  end

  always_comb begin
    geo_d.hit     = hit_q;
    geo_d.upd     = upd_q;
    geo_d.dot_neg = dot_q[DotW-1];
    geo_d.adot    = dot_q[DotW-1] ? AdotWidth'(-dot_q) : AdotWidth'(dot_q);
    geo_d.den     = DenWidth'(DenWidth'(m_q) * DenWidth'(dist2_q));
    geo_d.adx     = adx2_q;
    geo_d.dx_neg  = dxn2_q;
    geo_d.ady     = ady2_q;
    geo_d.dy_neg  = dyn2_q;
    geo_d.fa      = {d_q.a_mass, 1'b0};
    geo_d.fb      = {d_q.b_mass, 1'b0};
    geo_d.avx     = d_q.a_vel_x;
    geo_d.avy     = d_q.a_vel_y;
    geo_d.bvx     = d_q.b_vel_x;
    geo_d.bvy     = d_q.b_vel_y;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_q    <= in_i;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      rsum_q  <= rsum_d;
      dvx_q   <= dvx_d;
      dvy_q   <= dvy_d;
      b_q     <= in_q;
      near_q  <= near_d;
      sqx_q   <= sqx_d;
      sqy_q   <= sqy_d;
      rsq_q   <= rsq_d;
      px_q    <= px_d;
      py_q    <= py_d;
      adx_q   <= adx_c[15:0];
      ady_q   <= ady_c[15:0];
      dxn_q   <= dx_q[XW-1];
      dyn_q   <= dy_q[XW-1];
      c_q     <= b_q;
      dist2_q <= dist2_d;
      hit_q   <= hit_d;
      upd_q   <= hit_d && (m_d != '0);
      dot_q   <= dot_d;
      m_q     <= m_d;
      adx2_q  <= adx_q;
      ady2_q  <= ady_q;
      dxn2_q  <= dxn_q;
      dyn2_q  <= dyn_q;
      d_q     <= c_q;
      geo_q   <= geo_d;
    end
  end

  assign geo_o = geo_q;

endmodule

@@ rtl/dec_lane.sv @@
// One velocity lane: scaled quotient by a pipelined restoring divider, then saturation.
`timescale 1ns / 1ps
module dec_lane (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic [dec_pkg::AdotWidth-1:0]           adot_i,
  input  logic [dec_pkg::FactWidth-1:0]           fact_i,
  input  logic [dec_pkg::CompWidth-1:0]           comp_i,
  input  logic [dec_pkg::DenWidth-1:0]            den_i,
  input  logic                                    minus_i,
  input  logic                                    upd_i,
  input  logic signed [dec_pkg::VelWidth-1:0]     vel_i,
  output logic signed [dec_pkg::VelWidth-1:0]     vel_o
);
  import dec_pkg::*;

  localparam int unsigned BW  = FactWidth + CompWidth;
  localparam int unsigned NW  = AdotWidth + BW;
  localparam int unsigned HW  = NW + 1 - QuoWidth;
  localparam int unsigned SW  = VelWidth + 3;
  localparam int unsigned P   = QuoWidth + 4;

  typedef struct packed {
    logic                       minus;
    logic                       upd;
    logic signed [VelWidth-1:0] vel;
  } side_t;

  logic [BW-1:0]        b_q;
  logic [AdotWidth-1:0] adot_q;
  logic [DenWidth-1:0]  den1_q, den2_q, den3_q;
  logic [NW-1:0]        num_q;
  logic [NW:0]          numh_q;
  logic [HW-1:0]        hiw;

  logic [DenWidth-1:0]  rem_q [0:QuoWidth];
  logic [DenWidth-1:0]  dvs_q [0:QuoWidth];
  logic [QuoWidth-1:0]  low_q [0:QuoWidth];
  logic [QuoWidth-1:0]  quo_q [0:QuoWidth];
  logic                 ovf_q [0:QuoWidth];
  side_t                side_q [0:P-1];

  logic signed [SW-1:0]       sum;
  logic signed [VelWidth-1:0] res;
  side_t                      fin;

  assign hiw = numh_q[NW:QuoWidth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_q      <= BW'(fact_i) * BW'(comp_i);
      adot_q   <= adot_i;
      den1_q   <= den_i;
      num_q    <= NW'(adot_q) * NW'(b_q);
      den2_q   <= den1_q;
      numh_q   <= (NW + 1)'(num_q) + (NW + 1)'(den2_q >> 1);
      den3_q   <= den2_q;
      ovf_q[0] <= hiw >= HW'(den3_q);
      rem_q[0] <= DenWidth'(hiw);
      low_q[0] <= numh_q[QuoWidth-1:0];
      quo_q[0] <= '0;
      dvs_q[0] <= den3_q;
    end
  end

  for (genvar k = 1; k <= QuoWidth; k++) begin : g_div
    logic [DenWidth:0] t;
    assign t = {rem_q[k-1], low_q[k-1][QuoWidth-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (t >= {1'b0, dvs_q[k-1]}) begin
          rem_q[k] <= DenWidth'(t - {1'b0, dvs_q[k-1]});
          quo_q[k] <= {quo_q[k-1][QuoWidth-2:0], 1'b1};
        end else begin
          rem_q[k] <= t[DenWidth-1:0];
          quo_q[k] <= {quo_q[k-1][QuoWidth-2:0], 1'b0};
        end
        low_q[k] <= {low_q[k-1][QuoWidth-2:0], 1'b0};
        dvs_q[k] <= dvs_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= '{minus: minus_i, upd: upd_i, vel: vel_i};
    end
  end

  for (genvar s = 1; s < P; s++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  always_comb begin
    fin = side_q[P-1];
    if (fin.minus) begin
      sum = SW'(fin.vel) - SW'({1'b0, quo_q[QuoWidth]});
    end else begin
      sum = SW'(fin.vel) + SW'({1'b0, quo_q[QuoWidth]});
    end
    if (!fin.upd) begin
      res = fin.vel;
    end else if (ovf_q[QuoWidth]) begin
      res = fin.minus ? {1'b1, {(VelWidth-1){1'b0}}} : {1'b0, {(VelWidth-1){1'b1}}};
    end else if (sum[SW-1:VelWidth-1] == '0 || sum[SW-1:VelWidth-1] == '1) begin
      res = sum[VelWidth-1:0];
    end else begin
      res = sum[SW-1] ? {1'b1, {(VelWidth-1){1'b0}}} : {1'b0, {(VelWidth-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vel_o <= res;
    end
  end

endmodule

@@ rtl/disk_elastic_collision.sv @@
// Top level of the disk collision block: front end, four velocity lanes, merge and output skid.
// Path: an input transfer passes the front end registers, then the lane registers, then
//   the output register before its result can transfer. The one-bit-per-stage divider
//   in each lane makes up most of that path.
// Throughput: one disk pair per cycle; the whole pipeline moves while the skid stage is empty.
// Reset: rst_ni clears the valid chain, the output register flag and the skid flag; the
//   datapath registers carry no reset.
`timescale 1ns / 1ps
module disk_elastic_collision (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dec_pkg::dec_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dec_pkg::dec_out_t out_data_o
);
  import dec_pkg::*;

  localparam int unsigned Lat = FrontLat + LaneLat;

  // The pipeline advances as one; it stops only when the skid stage holds a result.
  logic     en;
  logic     skid_full_q;
  logic [Lat-1:0] vld_q;
  logic     hit_dly_q [0:LaneLat-1];
  dec_geo_t geo;
  dec_out_t res;
  dec_out_t out_q, skid_q;
  logic     out_valid_q;
  logic     take;

  assign en         = !skid_full_q;
  assign in_ready_o = en;
  assign take       = out_valid_q && out_ready_i;

  dec_front u_front (
    .clk_i (clk_i),
    .en_i  (en),
    .in_i  (in_data_i),
    .geo_o (geo)
  );

  // Four lanes, one per velocity component. For disk A the quotient is subtracted when the
  // dot product and the distance component share a sign; for disk B it is added then.
  dec_lane u_lane_ax (
    .clk_i (clk_i), .en_i (en), .adot_i (geo.adot), .fact_i (geo.fb), .comp_i (geo.adx),
    .den_i (geo.den), .minus_i (!(geo.dot_neg ^ geo.dx_neg)), .upd_i (geo.upd),
    .vel_i (geo.avx), .vel_o (res.a_new_vel_x)
  );
  dec_lane u_lane_ay (
    .clk_i (clk_i), .en_i (en), .adot_i (geo.adot), .fact_i (geo.fb), .comp_i (geo.ady),
    .den_i (geo.den), .minus_i (!(geo.dot_neg ^ geo.dy_neg)), .upd_i (geo.upd),
    .vel_i (geo.avy), .vel_o (res.a_new_vel_y)
  );
  dec_lane u_lane_bx (
    .clk_i (clk_i), .en_i (en), .adot_i (geo.adot), .fact_i (geo.fa), .comp_i (geo.adx),
    .den_i (geo.den), .minus_i (geo.dot_neg ^ geo.dx_neg), .upd_i (geo.upd),
    .vel_i (geo.bvx), .vel_o (res.b_new_vel_x)
  );
  dec_lane u_lane_by (
    .clk_i (clk_i), .en_i (en), .adot_i (geo.adot), .fact_i (geo.fa), .comp_i (geo.ady),
    .den_i (geo.den), .minus_i (geo.dot_neg ^ geo.dy_neg), .upd_i (geo.upd),
    .vel_i (geo.bvy), .vel_o (res.b_new_vel_y)
  );

  // The contact flag travels beside the lanes so that it meets their results.
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_dly_q[0] <= geo.hit;
    end
  end

  for (genvar s = 1; s < LaneLat; s++) begin : g_hit
    always_ff @(posedge clk_i) begin
      if (en) begin
        hit_dly_q[s] <= hit_dly_q[s-1];
      end
    end
  end

  assign res.hit = hit_dly_q[LaneLat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  // Output register with a one-entry skid stage behind it. A result arriving while the
  // output waits unsold goes to the skid stage, which then holds the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (take) begin
        skid_full_q <= 1'b0;
      end
    end else if (vld_q[Lat-1]) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_full_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (vld_q[Lat-1]) begin
      if (!out_valid_q || take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_skid_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |-> out_valid_q)
    else $error("skid stage full while output register is empty");
  a_last_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[Lat-1]) |=> out_valid_q)
    else $error("finished result was not placed in the output register");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_full_q && !take) |=> (skid_full_q && $stable(vld_q)))
    else $error("pipeline moved while the skid stage was full");
`endif

endmodule
